/* hw/rtl/lsc_pkg.sv */
// shared types and constants for the set-associative cache tag unit
`default_nettype none

package lsc_pkg;

	localparam int DEF_MAX_SET_BITS = 6;
	localparam int DEF_MAX_WAYS     = 4;

	localparam int ADDR_W  = 64;
	localparam int STAMP_W = 64;
	localparam int CNT_W   = 32;
	localparam int CFG_W   = 6;

	localparam logic [2:0] RST_SET_INDEX_BITS    = 3'd4;
	localparam logic [2:0] RST_WAYS_IN_USE       = 3'd1;
	localparam logic [5:0] RST_BLOCK_OFFSET_BITS = 6'd4;

	typedef enum logic [1:0] {
		CFG_SET_INDEX_BITS    = 2'd0,
		CFG_WAYS_IN_USE       = 2'd1,
		CFG_BLOCK_OFFSET_BITS = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_STORE  = 2'd1,
		OP_MODIFY = 2'd2,
		OP_OTHER  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_COMPARE,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic             miss;
		logic             eviction;
		logic             ignored;
		logic [CNT_W-1:0] hit_count;
		logic [CNT_W-1:0] miss_count;
		logic [CNT_W-1:0] eviction_count;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic decode;
		logic scan_clr;
		logic rd;
		logic cmp;
		logic commit;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ignored_op;
		logic modify_op;
		logic hit_now;
		logic last_way;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

/* hw/rtl/lsc_ctrl.sv */
// sequencing state machine for the cache tag unit
`default_nettype none

module lsc_ctrl import lsc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	output logic       req_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q, state_nxt;
	logic   pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DECODE) begin
				pass_q <= 1'b0;
			end else if (state_q == ST_UPDATE) begin
				pass_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_nxt = stat.ignored_op ? ST_FINISH : ST_READ;
			end
			ST_READ: begin
				state_nxt = ST_COMPARE;
			end
			ST_COMPARE: begin
				if (stat.hit_now || stat.last_way) begin
					state_nxt = ST_UPDATE;
				end else begin
					state_nxt = ST_READ;
				end
			end
			ST_UPDATE: begin
				// modify scans the set a second time
				state_nxt = (stat.modify_op && !pass_q) ? ST_READ : ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready    = (state_q == ST_IDLE);
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && req_valid;
		cmd.decode   = (state_q == ST_DECODE);
		cmd.scan_clr = (state_q == ST_DECODE) || (state_q == ST_UPDATE);
		cmd.rd       = (state_q == ST_READ);
		cmd.cmp      = (state_q == ST_COMPARE);
		cmd.commit   = (state_q == ST_UPDATE);
		cmd.out_load = (state_q == ST_FINISH) && stat.out_free;
	end

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.decode, cmd.rd, cmd.cmp, cmd.commit, cmd.out_load}))
		else $error("controller issued overlapping datapath commands");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded while output register still full");

endmodule

`default_nettype wire

/* hw/rtl/lsc_dpath.sv */
// tag/stamp memory, way scan, counters and result register
`default_nettype none

module lsc_dpath import lsc_pkg::*; #(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	output stat_t           stat,
	input  wire req_t       req,
	input  wire logic [2:0] set_index_bits,
	input  wire logic [2:0] ways_in_use,
	input  wire logic [5:0] block_offset_bits,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output rsp_t            rsp
);

	localparam int LINE_COUNT = (2 ** MAX_SET_BITS) * MAX_WAYS;
	localparam int LINE_W     = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
	localparam int SET_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W     = $clog2(MAX_WAYS + 1);

	// request and scan registers
	logic [1:0]         op_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [STAMP_W-1:0] time_q;
	logic [SET_W-1:0]   set_q;
	logic [ADDR_W-1:0]  tag_q;
	logic [WAY_W-1:0]   way_q;
	logic               first_q;
	logic [WAY_W-1:0]   oldest_q;
	logic [STAMP_W-1:0] oldest_stamp_q;
	logic               free_vld_q;
	logic [WAY_W-1:0]   free_way_q;
	logic               hit_q;
	logic [WAY_W-1:0]   hit_way_q;
	logic               flag_hit_q;
	logic               flag_miss_q;
	logic               flag_evict_q;
	logic [CNT_W-1:0]   hits_q;
	logic [CNT_W-1:0]   misses_q;
	logic [CNT_W-1:0]   evicts_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	// line storage
	line_t                 line_mem [LINE_COUNT];
	logic [LINE_COUNT-1:0] valid_q;
	line_t                 rd_line_q;
	logic                  rd_vld_q;

	logic [2:0]         sbits;
	logic [WCNT_W-1:0]  ways_eff;
	logic [ADDR_W-1:0]  shifted;
	logic [7:0]         smask;
	logic [7:0]         set_sel;
	logic [6:0]         tag_sh;
	logic [ADDR_W-1:0]  tag_val;
	logic [LINE_W-1:0]  rd_idx;
	logic [LINE_W-1:0]  wr_idx;
	logic [WAY_W-1:0]   wr_way;
	logic               hit_now;

	always_comb begin
		if (int'(set_index_bits) > MAX_SET_BITS) begin
			sbits = 3'(MAX_SET_BITS);
		end else begin
			sbits = set_index_bits;
		end
		if (ways_in_use == 3'd0) begin
			ways_eff = WCNT_W'(1);
		end else if (int'(ways_in_use) > MAX_WAYS) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WCNT_W'(ways_in_use);
		end
	end

	// address split
	assign shifted = addr_q >> block_offset_bits;
	assign smask   = 8'((9'd1 << sbits) - 9'd1);
	assign set_sel = shifted[7:0] & smask;
	assign tag_sh  = 7'(block_offset_bits) + 7'(sbits);
	assign tag_val = (tag_sh < 7'd64) ? (addr_q >> tag_sh) : '0;

	assign rd_idx = LINE_W'(LINE_W'(set_q) * LINE_W'(MAX_WAYS) + LINE_W'(way_q));
	assign wr_way = hit_q ? hit_way_q : (free_vld_q ? free_way_q : oldest_q);
	assign wr_idx = LINE_W'(LINE_W'(set_q) * LINE_W'(MAX_WAYS) + LINE_W'(wr_way));

	assign hit_now = rd_vld_q && (rd_line_q.tag == tag_q);

	always_comb begin
		stat            = '0;
		stat.ignored_op = (op_q == OP_OTHER);
		stat.modify_op  = (op_q == OP_MODIFY);
		stat.hit_now    = hit_now;
		stat.last_way   = (WCNT_W'(WCNT_W'(way_q) + WCNT_W'(1)) == ways_eff);
		stat.out_free   = !rsp_valid_q || rsp_ready;
	end

	// control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				time_q <= time_q + STAMP_W'(1);
			end
			if (cmd.commit) begin
				if (hit_q) begin
					hits_q <= (hits_q == '1) ? hits_q : hits_q + CNT_W'(1);
				end else begin
					misses_q      <= (misses_q == '1) ? misses_q : misses_q + CNT_W'(1);
					valid_q[wr_idx] <= 1'b1;
					if (!free_vld_q) begin
						evicts_q <= (evicts_q == '1) ? evicts_q : evicts_q + CNT_W'(1);
					end
				end
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// line memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			line_mem[wr_idx] <= '{tag: tag_q, stamp: time_q};
		end
		if (cmd.rd) begin
			rd_line_q <= line_mem[rd_idx];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= req.opcode;
			addr_q       <= req.address;
			flag_hit_q   <= 1'b0;
			flag_miss_q  <= 1'b0;
			flag_evict_q <= 1'b0;
		end
		if (cmd.decode) begin
			set_q <= SET_W'(set_sel);
			tag_q <= tag_val;
		end
		if (cmd.scan_clr) begin
			way_q      <= '0;
			first_q    <= 1'b1;
			free_vld_q <= 1'b0;
			hit_q      <= 1'b0;
		end
		if (cmd.rd) begin
			rd_vld_q <= valid_q[rd_idx];
		end
		if (cmd.cmp) begin
			way_q <= way_q + WAY_W'(1);
			if (hit_now) begin
				hit_q     <= 1'b1;
				hit_way_q <= way_q;
			end else begin
				// strict compare keeps the lowest way on equal stamps
				if (first_q || (rd_line_q.stamp < oldest_stamp_q)) begin
					oldest_q       <= way_q;
					oldest_stamp_q <= rd_line_q.stamp;
					first_q        <= 1'b0;
				end
				if (!rd_vld_q) begin
					free_vld_q <= 1'b1;
					free_way_q <= way_q;
				end
			end
		end
		if (cmd.commit) begin
			if (hit_q) begin
				flag_hit_q <= 1'b1;
			end else begin
				flag_miss_q <= 1'b1;
				if (!free_vld_q) begin
					flag_evict_q <= 1'b1;
				end
			end
		end
		if (cmd.out_load) begin
			rsp_q.hit            <= flag_hit_q;
			rsp_q.miss           <= flag_miss_q;
			rsp_q.eviction       <= flag_evict_q;
			rsp_q.ignored        <= (op_q == OP_OTHER);
			rsp_q.hit_count      <= hits_q;
			rsp_q.miss_count     <= misses_q;
			rsp_q.eviction_count <= evicts_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> valid_q[$past(wr_idx)])
		else $error("line written by update is not marked valid");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.eviction |-> rsp_q.miss && !rsp_q.ignored)
		else $error("eviction reported without a miss");

	a_hits_step: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q != $past(hits_q) |-> hits_q == $past(hits_q) + CNT_W'(1))
		else $error("hit counter moved by more than one");

endmodule

`default_nettype wire

/* hw/rtl/lru_set_assoc_cache_tags_unit.sv */
// Tag and LRU replacement unit of a set-associative cache.
// Requests (opcode, address) enter on req_valid/req_ready; one response per
// request leaves on rsp_valid/rsp_ready with hit/miss/eviction/ignored flags
// and saturating running totals. Configuration must be written through cfg_we,
// cfg_idx and cfg_wdata only while no request is in flight; the block does not enforce it.
// From request accept to rsp_valid, load and store go through a decode step,
// then, for each way read before a hit or the end of the set, a read of the
// line memory and a compare, then an update and the loading of the response.
// Modify makes two such passes; an ignored opcode goes from decode to the response.
// The next request is taken in the cycle after the response is loaded, so one
// request is in work at a time.
// Reset clears the valid bits, the access time and the counters at once and
// loads the default configuration; no clearing pass is needed.
// A stalled response stays in the output register while the next request
// is accepted and worked; that request then waits for the register to free.
`default_nettype none

module lru_set_assoc_cache_tags_unit import lsc_pkg::*; #(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output rsp_t                  rsp,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	logic [2:0] set_index_bits_q;
	logic [2:0] ways_in_use_q;
	logic [5:0] block_offset_bits_q;
	cmd_t       cmd;
	stat_t      stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_index_bits_q    <= RST_SET_INDEX_BITS;
			ways_in_use_q       <= RST_WAYS_IN_USE;
			block_offset_bits_q <= RST_BLOCK_OFFSET_BITS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SET_INDEX_BITS:    set_index_bits_q    <= cfg_wdata[2:0];
				CFG_WAYS_IN_USE:       ways_in_use_q       <= cfg_wdata[2:0];
				CFG_BLOCK_OFFSET_BITS: block_offset_bits_q <= cfg_wdata[5:0];
				default: begin
				end
			endcase
		end
	end

	lsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lsc_dpath #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.req               (req),
		.set_index_bits    (set_index_bits_q),
		.ways_in_use       (ways_in_use_q),
		.block_offset_bits (block_offset_bits_q),
		.rsp_valid         (rsp_valid),
		.rsp_ready         (rsp_ready),
		.rsp               (rsp)
	);

endmodule

`default_nettype wire

/* tb/tb_lru_set_assoc_cache_tags_unit.sv */
// self-checking testbench for the set-associative cache tag and lru unit
module tb_lru_set_assoc_cache_tags_unit;
	import lsc_pkg::*;

	localparam int SET_BITS_MAX = DEF_MAX_SET_BITS;
	localparam int WAYS_MAX     = DEF_MAX_WAYS;
	localparam int LINES        = (1 << SET_BITS_MAX) * WAYS_MAX;
	localparam int SETTLE       = 40;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASE_ITEMS  = 110;

	localparam logic [2:0] HIT_F   = 3'b100;
	localparam logic [2:0] MISS_F  = 3'b010;
	localparam logic [2:0] EVICT_F = 3'b001;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	lru_set_assoc_cache_tags_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// predicted cache contents
	bit [63:0] line_tag [LINES];
	bit        line_valid [LINES];
	bit [63:0] line_stamp [LINES];
	bit [63:0] access_clock;
	bit [31:0] hits_seen, misses_seen, evictions_seen;

	logic [2:0] cfg_sbits = RST_SET_INDEX_BITS;
	logic [2:0] cfg_ways  = RST_WAYS_IN_USE;
	logic [5:0] cfg_boff  = RST_BLOCK_OFFSET_BITS;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	bit calm = 1'b0;
	int fail_count = 0;
	int send_hold = 0;
	int stall_hold = 0;
	int cycle_count = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic bit [31:0] sat_inc(bit [31:0] v);
		return (v == 32'hffff_ffff) ? v : v + 32'd1;
	endfunction

	function automatic int unsigned eff_set_bits();
		return (cfg_sbits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_sbits;
	endfunction

	// one walk over the ways of a set; hit refreshes, miss fills or evicts lru
	function automatic logic [2:0] scan_set(int unsigned set_n, logic [63:0] tag,
			int unsigned ways);
		int unsigned base;
		int unsigned idx;
		int unsigned oldest;
		logic [63:0] oldest_stamp;
		int free_way;
		base = set_n * WAYS_MAX;
		oldest = 0;
		oldest_stamp = '1;
		free_way = -1;
		for (int unsigned w = 0; w < ways; w++) begin
			idx = base + w;
			if (line_valid[idx] && line_tag[idx] == tag) begin
				line_stamp[idx] = access_clock;
				hits_seen = sat_inc(hits_seen);
				return HIT_F;
			end
			if (w == 0 || line_stamp[idx] < oldest_stamp) begin
				oldest_stamp = line_stamp[idx];
				oldest = w;
			end
			if (!line_valid[idx])
				free_way = w;
		end
		misses_seen = sat_inc(misses_seen);
		if (free_way >= 0) begin
			idx = base + free_way;
			line_valid[idx] = 1'b1;
			line_tag[idx] = tag;
			line_stamp[idx] = access_clock;
			return MISS_F;
		end
		idx = base + oldest;
		line_tag[idx] = tag;
		line_stamp[idx] = access_clock;
		evictions_seen = sat_inc(evictions_seen);
		return MISS_F | EVICT_F;
	endfunction

	function automatic rsp_t predict_access(req_t r);
		rsp_t e;
		int unsigned sb;
		int unsigned ways;
		int unsigned bo;
		int unsigned set_n;
		logic [63:0] tag;
		logic [2:0] fl;
		sb = eff_set_bits();
		ways = (cfg_ways < 1) ? 1 : (cfg_ways > WAYS_MAX) ? WAYS_MAX : cfg_ways;
		bo = cfg_boff;
		set_n = int'((r.address >> bo) & ((64'd1 << sb) - 64'd1));
		tag = (bo + sb < 64) ? (r.address >> (bo + sb)) : 64'd0;
		access_clock = access_clock + 64'd1;
		fl = '0;
		case (r.opcode)
			OP_LOAD, OP_STORE: begin
				fl = scan_set(set_n, tag, ways);
			end
			OP_MODIFY: begin
				fl = scan_set(set_n, tag, ways);
				fl |= scan_set(set_n, tag, ways);
			end
			default: begin
			end
		endcase
		e.hit = |(fl & HIT_F);
		e.miss = |(fl & MISS_F);
		e.eviction = |(fl & EVICT_F);
		e.ignored = (r.opcode == OP_OTHER);
		e.hit_count = hits_seen;
		e.miss_count = misses_seen;
		e.eviction_count = evictions_seen;
		return e;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				expected_rsps.push_back(predict_access(req));
			if (!req_valid || req_ready) begin
				if (send_hold > 0) begin
					send_hold <= send_hold - 1;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					if (!calm && $urandom_range(0, 5) == 0) begin
						send_hold <= $urandom_range(0, 3);
						req_valid <= 1'b0;
					end else begin
						req <= pending_reqs.pop_front();
						req_valid <= 1'b1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_rsp(rsp_t got);
		rsp_t want;
		if (expected_rsps.size() == 0) begin
			$error("response with no request outstanding");
			fail_count++;
		end else begin
			want = expected_rsps.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, got.hit);
				fail_count++;
			end
			if (got.miss !== want.miss) begin
				$error("miss: expected %0d, got %0d", want.miss, got.miss);
				fail_count++;
			end
			if (got.eviction !== want.eviction) begin
				$error("eviction: expected %0d, got %0d", want.eviction, got.eviction);
				fail_count++;
			end
			if (got.ignored !== want.ignored) begin
				$error("ignored: expected %0d, got %0d", want.ignored, got.ignored);
				fail_count++;
			end
			if (got.hit_count !== want.hit_count) begin
				$error("hit_count: expected %0d, got %0d", want.hit_count, got.hit_count);
				fail_count++;
			end
			if (got.miss_count !== want.miss_count) begin
				$error("miss_count: expected %0d, got %0d", want.miss_count, got.miss_count);
				fail_count++;
			end
			if (got.eviction_count !== want.eviction_count) begin
				$error("eviction_count: expected %0d, got %0d", want.eviction_count,
					got.eviction_count);
				fail_count++;
			end
		end
	endtask

	// response monitor with random back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				check_rsp(rsp);
			if (stall_hold > 0) begin
				stall_hold <= stall_hold - 1;
				rsp_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_hold <= $urandom_range(0, 3);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic push_req(op_t op, logic [63:0] addr);
		req_t r;
		r.opcode = op;
		r.address = addr;
		pending_reqs.push_back(r);
	endtask

	task automatic set_config(logic [2:0] sb, logic [2:0] ways, logic [5:0] bo);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_SET_INDEX_BITS;
		cfg_wdata <= CFG_W'(sb);
		@(posedge clk);
		cfg_idx <= CFG_WAYS_IN_USE;
		cfg_wdata <= CFG_W'(ways);
		@(posedge clk);
		cfg_idx <= CFG_BLOCK_OFFSET_BITS;
		cfg_wdata <= bo;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_sbits = sb;
		cfg_ways = ways;
		cfg_boff = bo;
	endtask

	// hold off until every request has been answered and the block is quiet
	task automatic drain_block();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [63:0] place_addr(logic [63:0] tagv, logic [63:0] setv);
		int unsigned sb;
		int unsigned bo;
		logic [63:0] a;
		sb = eff_set_bits();
		bo = cfg_boff;
		a = {$urandom, $urandom} & ((64'd1 << bo) - 64'd1);
		a |= (setv & ((64'd1 << sb) - 64'd1)) << bo;
		if (bo + sb < 64)
			a |= tagv << (bo + sb);
		return a;
	endfunction

	// mostly conflicting accesses over few tags and sets, some random noise
	task automatic random_phase(int n);
		logic [63:0] tag_pool [8];
		logic [63:0] set_pool [3];
		int pool_n;
		int made;
		req_t r;
		pool_n = $urandom_range(2, 8);
		for (int i = 0; i < 8; i++)
			tag_pool[i] = {$urandom, $urandom};
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		set_pool[0] = '0;
		set_pool[1] = '1;
		set_pool[2] = {$urandom, $urandom};
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 9) == 0)
				r.opcode = OP_OTHER;
			else
				r.opcode = 2'($urandom_range(0, 2));
			if ($urandom_range(0, 11) == 0)
				r.address = {$urandom, $urandom};
			else
				r.address = place_addr(tag_pool[$urandom_range(0, pool_n - 1)],
					set_pool[$urandom_range(0, 2)]);
			pending_reqs.push_back(r);
			made++;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default setup: one way, so any new tag in a filled set evicts
		push_req(OP_LOAD, 64'h0);
		push_req(OP_LOAD, 64'hf);
		push_req(OP_STORE, 64'h0);
		push_req(OP_LOAD, 64'h100);
		push_req(OP_MODIFY, 64'h200);
		push_req(OP_MODIFY, 64'h200);
		push_req(OP_OTHER, '1);
		push_req(OP_LOAD, '1);
		push_req(OP_STORE, 64'h8000_0000_0000_0000);
		push_req(OP_OTHER, 64'h0);
		drain_block();

		// single set, four ways: fill order, lru victim, modify miss then hit
		set_config(3'd0, 3'd4, 6'd0);
		push_req(OP_LOAD, 64'd1);
		push_req(OP_LOAD, 64'd2);
		push_req(OP_LOAD, 64'd3);
		push_req(OP_LOAD, 64'd4);
		push_req(OP_LOAD, 64'd1);
		push_req(OP_STORE, 64'd5);
		push_req(OP_MODIFY, 64'd2);
		push_req(OP_LOAD, 64'd3);
		push_req(OP_MODIFY, 64'd1);
		drain_block();

		set_config(3'd6, 3'd4, 6'd6);
		random_phase(PHASE_ITEMS);
		drain_block();
		set_config(3'd7, 3'd7, 6'd63);
		random_phase(PHASE_ITEMS);
		drain_block();
		set_config(3'd0, 3'd0, 6'd32);
		random_phase(PHASE_ITEMS);
		drain_block();
		set_config(3'd2, 3'd2, 6'd5);
		random_phase(PHASE_ITEMS);
		drain_block();
		set_config(3'd3, 3'd3, 6'd1);
		random_phase(PHASE_ITEMS);
		drain_block();
		set_config(3'd5, 3'd5, 6'd12);
		random_phase(PHASE_ITEMS);
		drain_block();
		set_config(3'd1, 3'd4, 6'd60);
		random_phase(PHASE_ITEMS);
		drain_block();
		set_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
			6'($urandom_range(0, 10)));
		random_phase(PHASE_ITEMS);
		drain_block();

		// no idling on either side for the tail of the run
		calm = 1'b1;
		set_config(3'd6, 3'd6, 6'd0);
		random_phase(PHASE_ITEMS);
		drain_block();
		set_config(3'd4, 3'd4, 6'd4);
		random_phase(PHASE_ITEMS);
		drain_block();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
